// ----- sv/cis_pkg.sv -----
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types, register indexes and helpers for the case-insensitive
// substring search core.
// ----------------------------------------------------------------------------
package cis_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int MAX_TEXT_DEFAULT    = 65536;

   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 5;
   localparam int OFFSET_W     = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int PATTERN_REGS = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PATTERN_LOW  = csr_index_type'(0);
   localparam csr_index_type CSR_PATTERN_HIGH = csr_index_type'(1);
   localparam csr_index_type CSR_PATTERN_LEN  = csr_index_type'(2);

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last_of_text;
   } req_word_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] start_offset;
   } rsp_word_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(
      input logic [CSR_DATA_W-1:0] low,
      input logic [CSR_DATA_W-1:0] high,
      input logic [LEN_W-1:0]      idx
   );
      logic [2*CSR_DATA_W-1:0] flat;
      logic [BYTE_W-1:0]       r;
      flat = {high, low};
      r    = '0;
      if (idx[LEN_W-1] == 1'b0) begin
         r = flat[idx[LEN_W-2:0]*BYTE_W +: BYTE_W];
      end
      return r;
   endfunction

endpackage

// ----- sv/cis_window_match.sv -----
// ----------------------------------------------------------------------------
// cis_window_match
// Compares the newest text bytes against the pattern, all positions at once,
// with ASCII letters folded to lower case.
// ----------------------------------------------------------------------------
module cis_window_match #(
   parameter int MAX_PATTERN = cis_pkg::MAX_PATTERN_DEFAULT,
   parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic [cis_pkg::BYTE_W-1:0]     window [MAX_PATTERN],
   input  logic [FILL_W-1:0]              fill_count,
   input  logic [cis_pkg::CSR_DATA_W-1:0] pattern_low,
   input  logic [cis_pkg::CSR_DATA_W-1:0] pattern_high,
   input  logic [cis_pkg::LEN_W-1:0]      pattern_len,
   output logic [cis_pkg::LEN_W-1:0]      match_len,
   output logic                           hit
);

   localparam int CMP_W = (FILL_W > cis_pkg::LEN_W) ? FILL_W : cis_pkg::LEN_W;
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PATTERN);

   logic [CMP_W-1:0]         len_wide;
   logic [cis_pkg::LEN_W-1:0] len;
   logic [MAX_PATTERN-1:0]   pos_ok;

   always_comb begin
      len_wide = CMP_W'(pattern_len);
      if (len_wide > MAX_LEN) begin
         len_wide = MAX_LEN;
      end
      len = cis_pkg::LEN_W'(len_wide);
   end

   always_comb begin
      logic [cis_pkg::LEN_W-1:0] idx;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         idx = len - cis_pkg::LEN_W'(1) - cis_pkg::LEN_W'(j);
         pos_ok[j] = (CMP_W'(j) >= len_wide) ||
                     (cis_pkg::fold_case(window[j]) ==
                      cis_pkg::fold_case(cis_pkg::pattern_byte(pattern_low,
                                                               pattern_high, idx)));
      end
   end

   assign match_len = len;
   assign hit       = (CMP_W'(fill_count) >= len_wide) && (&pos_ok);

endmodule

// ----- sv/case_insensitive_substring_search_core.sv -----
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_core
// Finds the first case-insensitive occurrence of a 1 to 16 byte pattern in a
// byte stream and reports found with its start offset, or not found at the
// end of the text.
//
// The core takes one text byte per clock and gives one result per text:
// found with the start offset at the first complete match, or not found at
// the byte marked last. Each byte goes through the window compare logic into
// the result register, so its result is registered in the cycle after the
// byte is taken, at one byte per cycle whenever the result side is ready.
// Bytes that follow a match give no result; the last byte of the text
// rearms the core. Offsets saturate at the smaller of MAX_TEXT-1 and 65535.
// The user must write pattern registers through the csr port only while no
// text is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_core #(
   parameter int MAX_PATTERN = cis_pkg::MAX_PATTERN_DEFAULT,
   parameter int MAX_TEXT    = cis_pkg::MAX_TEXT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cis_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cis_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  cis_pkg::csr_index_type         csr_index,
   input  logic [cis_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int FILL_W = $clog2(MAX_PATTERN + 1);
   localparam int OW     = cis_pkg::OFFSET_W;
   localparam logic [OW-1:0] COUNT_LIMIT =
      (MAX_TEXT - 1 > 65535) ? {OW{1'b1}} : OW'(MAX_TEXT - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);

   logic [cis_pkg::CSR_DATA_W-1:0] pat_low_ff, pat_high_ff;
   logic [cis_pkg::LEN_W-1:0]      pat_len_ff;

   logic [cis_pkg::BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [cis_pkg::BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [OW-1:0]              seen_ff, seen_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic                       reported_ff, reported_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cis_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   logic                      req_fire;
   logic                      hit;
   logic [cis_pkg::LEN_W-1:0] match_len;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= cis_pkg::LEN_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            cis_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            cis_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            cis_pkg::CSR_PATTERN_LEN:  pat_len_ff  <= csr_data[cis_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      win_in[0] = req_word.text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         win_in[j] = win_ff[j-1];
      end
      seen_in = (seen_ff < COUNT_LIMIT) ? seen_ff + OW'(1) : seen_ff;
      fill_in = (fill_ff < FILL_MAX) ? fill_ff + FILL_W'(1) : fill_ff;
   end

   cis_window_match #(
      .MAX_PATTERN(MAX_PATTERN),
      .FILL_W     (FILL_W)
   ) u_match (
      .window      (win_in),
      .fill_count  (fill_in),
      .pattern_low (pat_low_ff),
      .pattern_high(pat_high_ff),
      .pattern_len (pat_len_ff),
      .match_len   (match_len),
      .hit         (hit)
   );

   always_comb begin
      logic out_fire;
      logic rearm;
      out_fire    = 1'b0;
      rearm       = 1'b0;
      reported_in = reported_ff;
      rsp_word_in = rsp_word_ff;
      if (req_fire) begin
         if (reported_ff) begin
            rearm = req_word.last_of_text;
         end else if (hit) begin
            out_fire             = 1'b1;
            rsp_word_in.found    = 1'b1;
            if (match_len == '0) begin
               rsp_word_in.start_offset = '0;
            end else if (seen_ff >= COUNT_LIMIT) begin
               rsp_word_in.start_offset = COUNT_LIMIT;
            end else begin
               rsp_word_in.start_offset = seen_ff - OW'(match_len) + OW'(1);
            end
            rearm       = req_word.last_of_text;
            reported_in = !req_word.last_of_text;
         end else if (req_word.last_of_text) begin
            out_fire                 = 1'b1;
            rsp_word_in.found        = 1'b0;
            rsp_word_in.start_offset = '0;
            rearm                    = 1'b1;
         end
      end
      if (rearm) begin
         reported_in = 1'b0;
      end
      rsp_valid_in = out_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         fill_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            if (req_word.last_of_text) begin
               seen_ff <= '0;
               fill_ff <= '0;
            end else if (!reported_ff) begin
               seen_ff <= seen_in;
               fill_ff <= fill_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !reported_ff) begin
         win_ff <= win_in;
      end
      if (req_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ----- sv/cis_checker.sv -----
// ----------------------------------------------------------------------------
// cis_checker
// Port-level checks for the case-insensitive substring search core, bound
// to the top level.
// ----------------------------------------------------------------------------
module cis_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input cis_pkg::req_word_type          req_word,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input cis_pkg::rsp_word_type          rsp_word,
   input logic                           csr_valid,
   input logic                           csr_ready
);

   // A stalled result word must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // A not-found result always carries a zero offset.
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.found |-> rsp_word.start_offset == '0)
      else $error("not-found result with nonzero offset");

   // With the result register empty the core must take input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // A result appears only in the cycle after an accepted word.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted word");

   // Configuration writes are never back-pressured.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind case_insensitive_substring_search_core cis_checker u_cis_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_word (req_word),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_word (rsp_word),
   .csr_valid(csr_valid),
   .csr_ready(csr_ready)
);
